>>> rtl/bpw_pkg.sv
// ----------------------------------------------------------------------------
// bpw_pkg: shared types and constants of the button pairing window block
// Payload structs, mode and event codes, register indexes, reset values and
// the reciprocal used to turn milliseconds into whole seconds.
// ----------------------------------------------------------------------------
`default_nettype none

package bpw_pkg;

  localparam int TIME_W = 32;
  localparam int MS_W   = 16;
  localparam int WIN_W  = 20;
  localparam int SEC_W  = 10;
  localparam int IDX_W  = 3;

  // input modes
  typedef enum logic [1:0] {
    MODE_POLL      = 2'd0,
    MODE_DELIVERED = 2'd1,
    MODE_SYNC      = 2'd2,
    MODE_UNPAIR    = 2'd3
  } mode_t;

  // button event codes
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_SHORT = 2'd1;
  localparam logic [1:0] EV_LONG  = 2'd2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_BUTTON_ENABLED  = 3'd0;
  localparam logic [IDX_W-1:0] REG_ACTIVE_LOW      = 3'd1;
  localparam logic [IDX_W-1:0] REG_DEBOUNCE_MS     = 3'd2;
  localparam logic [IDX_W-1:0] REG_LONG_PRESS_MS   = 3'd3;
  localparam logic [IDX_W-1:0] REG_LONG_HOLDOFF_MS = 3'd4;
  localparam logic [IDX_W-1:0] REG_WINDOW_MS       = 3'd5;
  localparam logic [IDX_W-1:0] REG_RETRY_MS        = 3'd6;

  // register reset values
  localparam logic            RST_BUTTON_ENABLED  = 1'b0;
  localparam logic            RST_ACTIVE_LOW      = 1'b1;
  localparam logic [MS_W-1:0] RST_DEBOUNCE_MS     = 16'd50;
  localparam logic [MS_W-1:0] RST_LONG_PRESS_MS   = 16'd7000;
  localparam logic [MS_W-1:0] RST_LONG_HOLDOFF_MS = 16'd2000;
  localparam logic [WIN_W-1:0] RST_WINDOW_MS      = 20'd50000;
  localparam logic [MS_W-1:0] RST_RETRY_MS        = 16'd2500;

  // x / 1000 == (x * DIV_MUL) >> DIV_SHIFT, exact for every 20-bit x
  localparam int              MUL_W     = 21;
  localparam int              DIV_SHIFT = 30;
  localparam logic [MUL_W-1:0] DIV_MUL  = 21'd1073742;
  localparam int              PROD_W    = WIN_W + MUL_W;
  localparam int              QUO_W     = PROD_W - DIV_SHIFT;
  localparam logic [SEC_W-1:0] SECONDS_MAX = 10'd1023;

  typedef struct packed {
    mode_t              mode;
    logic [TIME_W-1:0]  now_ms;
    logic               button_level;
  } in_t;

  typedef struct packed {
    logic [1:0]         button_event;
    logic               announce_request;
    logic [SEC_W-1:0]   seconds_left;
    logic               window_timeout;
    logic               pairing_active;
  } out_t;

  typedef struct packed {
    logic [IDX_W-1:0]   index;
    logic [WIN_W-1:0]   data;
  } cfg_wr_t;

  typedef struct packed {
    logic               button_enabled;
    logic               active_low;
    logic [MS_W-1:0]    debounce_ms;
    logic [MS_W-1:0]    long_press_ms;
    logic [MS_W-1:0]    long_holdoff_ms;
    logic [WIN_W-1:0]   window_ms;
    logic [MS_W-1:0]    retry_ms;
  } cfg_t;

  // result of the decision stage, before seconds are formed
  typedef struct packed {
    logic [1:0]         button_event;
    logic               announce_request;
    logic [WIN_W-1:0]   ms_left;
    logic               window_timeout;
    logic               pairing_active;
  } mid_t;

  // stage load strobes
  typedef struct packed {
    logic               in_load;
    logic               mid_load;
    logic               out_load;
  } pipe_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/bpw_stream_if.sv
// ----------------------------------------------------------------------------
// bpw_stream_if: valid/ready channel
// Carries one payload of type T per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpw_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/bpw_cfg.sv
// ----------------------------------------------------------------------------
// bpw_cfg: configuration register file
// Takes one write transaction per cycle; unknown indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module bpw_cfg (
  input  wire logic    clk,
  input  wire logic    rst_n,
  bpw_stream_if.sink   cfg_ch,
  output bpw_pkg::cfg_t cfg
);

  bpw_pkg::cfg_t cfg_r;
  bpw_pkg::cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  // decode the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.data.index)
        bpw_pkg::REG_BUTTON_ENABLED:  cfg_nxt.button_enabled  = cfg_ch.data.data[0];
        bpw_pkg::REG_ACTIVE_LOW:      cfg_nxt.active_low      = cfg_ch.data.data[0];
        bpw_pkg::REG_DEBOUNCE_MS:     cfg_nxt.debounce_ms     = cfg_ch.data.data[15:0];
        bpw_pkg::REG_LONG_PRESS_MS:   cfg_nxt.long_press_ms   = cfg_ch.data.data[15:0];
        bpw_pkg::REG_LONG_HOLDOFF_MS: cfg_nxt.long_holdoff_ms = cfg_ch.data.data[15:0];
        bpw_pkg::REG_WINDOW_MS:       cfg_nxt.window_ms       = cfg_ch.data.data;
        bpw_pkg::REG_RETRY_MS:        cfg_nxt.retry_ms        = cfg_ch.data.data[15:0];
        default:                      cfg_nxt = cfg_r;
      endcase
    end
  end

  // hold the registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.button_enabled  <= bpw_pkg::RST_BUTTON_ENABLED;
      cfg_r.active_low      <= bpw_pkg::RST_ACTIVE_LOW;
      cfg_r.debounce_ms     <= bpw_pkg::RST_DEBOUNCE_MS;
      cfg_r.long_press_ms   <= bpw_pkg::RST_LONG_PRESS_MS;
      cfg_r.long_holdoff_ms <= bpw_pkg::RST_LONG_HOLDOFF_MS;
      cfg_r.window_ms       <= bpw_pkg::RST_WINDOW_MS;
      cfg_r.retry_ms        <= bpw_pkg::RST_RETRY_MS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/bpw_core.sv
// ----------------------------------------------------------------------------
// bpw_core: input register, press and window state, decision register
// Evaluates the button first and the pairing window second for each poll.
// ----------------------------------------------------------------------------
`default_nettype none

module bpw_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bpw_pkg::pipe_ctrl_t ctrl,
  input  wire bpw_pkg::in_t       in_data,
  input  wire bpw_pkg::cfg_t      cfg,
  output bpw_pkg::mid_t           mid
);

  localparam int TW = bpw_pkg::TIME_W;

  bpw_pkg::in_t  in_r;
  bpw_pkg::mid_t mid_r;
  bpw_pkg::mid_t mid_nxt;

  logic          window_open_r,    window_open_nxt;
  logic [TW-1:0] window_start_r,   window_start_nxt;
  logic [TW-1:0] last_retry_r,     last_retry_nxt;
  logic          was_pressed_r,    was_pressed_nxt;
  logic [TW-1:0] press_start_r,    press_start_nxt;
  logic          long_fired_r,     long_fired_nxt;
  logic [TW-1:0] last_long_time_r, last_long_time_nxt;

  logic          pressed;
  logic [TW-1:0] held;
  logic [TW-1:0] since_long;
  logic [TW-1:0] elapsed;
  logic [TW-1:0] since_retry;

  assign mid = mid_r;

  always_comb begin
    mid_nxt            = '0;
    window_open_nxt    = window_open_r;
    window_start_nxt   = window_start_r;
    last_retry_nxt     = last_retry_r;
    was_pressed_nxt    = was_pressed_r;
    press_start_nxt    = press_start_r;
    long_fired_nxt     = long_fired_r;
    last_long_time_nxt = last_long_time_r;

    pressed     = cfg.button_enabled & (in_r.button_level ^ cfg.active_low);
    held        = in_r.now_ms - press_start_r;
    since_long  = in_r.now_ms - last_long_time_r;
    elapsed     = '0;
    since_retry = '0;

    unique case (in_r.mode)
      bpw_pkg::MODE_POLL: begin
        // button
        if (!pressed) begin
          if (was_pressed_r && !long_fired_r &&
              held >= {16'd0, cfg.debounce_ms} &&
              held <  {16'd0, cfg.long_press_ms}) begin
            mid_nxt.button_event = bpw_pkg::EV_SHORT;
          end
          was_pressed_nxt = 1'b0;
          press_start_nxt = '0;
          long_fired_nxt  = 1'b0;
        end else if (!was_pressed_r) begin
          was_pressed_nxt = 1'b1;
          press_start_nxt = in_r.now_ms;
          long_fired_nxt  = 1'b0;
        end else if (held >= {16'd0, cfg.long_press_ms} && !long_fired_r &&
                     since_long >= {16'd0, cfg.long_holdoff_ms}) begin
          long_fired_nxt       = 1'b1;
          last_long_time_nxt   = in_r.now_ms;
          window_open_nxt      = 1'b1;
          window_start_nxt     = in_r.now_ms;
          last_retry_nxt       = '0;
          mid_nxt.button_event = bpw_pkg::EV_LONG;
        end

        // window, on the state the button left
        elapsed     = in_r.now_ms - window_start_nxt;
        since_retry = in_r.now_ms - last_retry_nxt;
        if (window_open_nxt) begin
          if (elapsed > {12'd0, cfg.window_ms}) begin
            window_open_nxt        = 1'b0;
            mid_nxt.window_timeout = 1'b1;
          end else if (since_retry > {16'd0, cfg.retry_ms}) begin
            last_retry_nxt           = in_r.now_ms;
            mid_nxt.announce_request = 1'b1;
            mid_nxt.ms_left          = cfg.window_ms - elapsed[bpw_pkg::WIN_W-1:0];
          end
        end
      end
      bpw_pkg::MODE_DELIVERED,
      bpw_pkg::MODE_SYNC: begin
        window_open_nxt = 1'b0;
      end
      bpw_pkg::MODE_UNPAIR: begin
        window_open_nxt  = 1'b1;
        window_start_nxt = in_r.now_ms;
      end
      default: begin
        window_open_nxt = window_open_r;
      end
    endcase

    mid_nxt.pairing_active = window_open_nxt;
  end

  // capture the accepted transaction
  always_ff @(posedge clk) begin
    if (ctrl.in_load) begin
      in_r <= in_data;
    end
  end

  // advance state and the decision register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_open_r    <= 1'b0;
      window_start_r   <= '0;
      last_retry_r     <= '0;
      was_pressed_r    <= 1'b0;
      press_start_r    <= '0;
      long_fired_r     <= 1'b0;
      last_long_time_r <= '0;
    end else if (ctrl.mid_load) begin
      window_open_r    <= window_open_nxt;
      window_start_r   <= window_start_nxt;
      last_retry_r     <= last_retry_nxt;
      was_pressed_r    <= was_pressed_nxt;
      press_start_r    <= press_start_nxt;
      long_fired_r     <= long_fired_nxt;
      last_long_time_r <= last_long_time_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mid_load) begin
      mid_r <= mid_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/bpw_sec.sv
// ----------------------------------------------------------------------------
// bpw_sec: seconds conversion and result register
// Divides the remaining milliseconds by 1000 through a reciprocal multiply
// and saturates the count.
// ----------------------------------------------------------------------------
`default_nettype none

module bpw_sec (
  input  wire logic                clk,
  input  wire bpw_pkg::pipe_ctrl_t ctrl,
  input  wire bpw_pkg::mid_t       mid,
  output bpw_pkg::out_t            out_data
);

  logic [bpw_pkg::PROD_W-1:0] prod;
  logic [bpw_pkg::QUO_W-1:0]  quo;
  bpw_pkg::out_t              out_r;
  bpw_pkg::out_t              out_nxt;

  assign out_data = out_r;

  // form whole seconds, saturated
  always_comb begin
    prod = bpw_pkg::PROD_W'(mid.ms_left) * bpw_pkg::PROD_W'(bpw_pkg::DIV_MUL);
    quo  = prod[bpw_pkg::PROD_W-1:bpw_pkg::DIV_SHIFT];

    out_nxt.button_event     = mid.button_event;
    out_nxt.announce_request = mid.announce_request;
    out_nxt.window_timeout   = mid.window_timeout;
    out_nxt.pairing_active   = mid.pairing_active;
    if (quo > bpw_pkg::QUO_W'(bpw_pkg::SECONDS_MAX)) begin
      out_nxt.seconds_left = bpw_pkg::SECONDS_MAX;
    end else begin
      out_nxt.seconds_left = quo[bpw_pkg::SEC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_r <= out_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/button_press_pairing_window.sv
// ----------------------------------------------------------------------------
// button_press_pairing_window: press detector with pairing window
// A result passes the input register, the decision register and the result register.
// Throughput: one transaction per cycle unless the result channel stalls.
// Reset clears stage valids and state, and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module button_press_pairing_window (
  input  wire logic    clk,
  input  wire logic    rst_n,
  bpw_stream_if.sink   in_ch,
  bpw_stream_if.source out_ch,
  bpw_stream_if.sink   cfg_ch
);

  bpw_pkg::cfg_t      cfg;
  bpw_pkg::pipe_ctrl_t ctrl;
  bpw_pkg::mid_t      mid;
  bpw_pkg::in_t       in_data;

  logic in_v_r;
  logic mid_v_r;
  logic out_v_r;
  logic adv_in;
  logic adv_mid;
  logic adv_out;

  // each stage advances when it is empty or its successor moves
  assign adv_out = !out_v_r || out_ch.ready;
  assign adv_mid = !mid_v_r || adv_out;
  assign adv_in  = !in_v_r  || adv_mid;

  assign in_ch.ready   = adv_in;
  assign out_ch.valid  = out_v_r;
  assign in_data       = in_ch.data;

  assign ctrl.in_load  = in_ch.valid && adv_in;
  assign ctrl.mid_load = in_v_r && adv_mid;
  assign ctrl.out_load = mid_v_r && adv_out;

  // hold stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      mid_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (adv_in) begin
        in_v_r <= in_ch.valid;
      end
      if (adv_mid) begin
        mid_v_r <= in_v_r;
      end
      if (adv_out) begin
        out_v_r <= mid_v_r;
      end
    end
  end

  bpw_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  bpw_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .in_data (in_data),
    .cfg     (cfg),
    .mid     (mid)
  );

  bpw_sec u_sec (
    .clk      (clk),
    .ctrl     (ctrl),
    .mid      (mid),
    .out_data (out_ch.data)
  );

endmodule

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for button_press_pairing_window
// Drives polls and radio events on the input channel and writes the config
// registers between phases. A local predictor of the press detector and
// the pairing window works out every report, and each result transaction
// is compared field by field with the oldest expected report. Both
// channels idle and stall at random.
// ----------------------------------------------------------------------------

module tb;

  localparam int                        CYCLE_LIMIT = 400000;
  localparam int                        PIPE_SETTLE = 8;
  localparam int                        PHASE_ITEMS = 250;
  localparam int                        PHASE_COUNT = 6;
  localparam logic [bpw_pkg::TIME_W-1:0] MS_PER_S   = 32'd1000;
  localparam logic [bpw_pkg::IDX_W-1:0]  REG_UNUSED = 3'd7;

  logic clk;
  logic rst_n;

  bpw_stream_if #(.T(bpw_pkg::in_t))     in_if ();
  bpw_stream_if #(.T(bpw_pkg::out_t))    out_if ();
  bpw_stream_if #(.T(bpw_pkg::cfg_wr_t)) cfg_if ();

  button_press_pairing_window uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // register shadow and predicted press/window state
  bpw_pkg::cfg_t              cfg_now;
  logic                       pair_open;
  logic [bpw_pkg::TIME_W-1:0] pair_start;
  logic [bpw_pkg::TIME_W-1:0] last_announce;
  logic                       btn_down;
  logic [bpw_pkg::TIME_W-1:0] down_since;
  logic                       long_done;
  logic [bpw_pkg::TIME_W-1:0] last_long_at;

  bpw_pkg::out_t              reports_due[$];
  logic [bpw_pkg::TIME_W-1:0] clock_ms;
  int                         items_sent  = 0;
  int                         mismatches  = 0;
  int                         cycles      = 0;
  bit                         in_held     = 1'b0;
  bit                         src_steady  = 1'b0;
  bit                         sink_steady = 1'b0;
  bpw_pkg::out_t              want_rpt;
  bpw_pkg::out_t              got_rpt;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // evaluate the button on a poll; a long press also opens the window
  function automatic logic [1:0] judge_press(input logic [bpw_pkg::TIME_W-1:0] now,
                                             input logic level);
    logic                       pressed;
    logic [bpw_pkg::TIME_W-1:0] held;
    logic [bpw_pkg::TIME_W-1:0] since_long;
    pressed    = cfg_now.button_enabled && ((level == 1'b0) == cfg_now.active_low);
    held       = now - down_since;
    since_long = now - last_long_at;
    judge_press = bpw_pkg::EV_NONE;
    if (!pressed) begin
      if (btn_down && !long_done && held >= 32'(cfg_now.debounce_ms) &&
          held < 32'(cfg_now.long_press_ms))
        judge_press = bpw_pkg::EV_SHORT;
      btn_down   = 1'b0;
      down_since = '0;
      long_done  = 1'b0;
    end else if (!btn_down) begin
      btn_down   = 1'b1;
      down_since = now;
      long_done  = 1'b0;
    end else if (held >= 32'(cfg_now.long_press_ms) && !long_done &&
                 since_long >= 32'(cfg_now.long_holdoff_ms)) begin
      long_done     = 1'b1;
      last_long_at  = now;
      pair_open     = 1'b1;
      pair_start    = now;
      last_announce = '0;
      judge_press   = bpw_pkg::EV_LONG;
    end
  endfunction

  // work out the report of one input transaction and advance the state
  function automatic bpw_pkg::out_t next_report(input bpw_pkg::in_t item);
    bpw_pkg::out_t              rpt;
    logic [bpw_pkg::TIME_W-1:0] elapsed;
    logic [bpw_pkg::TIME_W-1:0] since_ann;
    logic [bpw_pkg::TIME_W-1:0] secs;
    rpt = '0;
    case (item.mode)
      bpw_pkg::MODE_POLL: begin
        rpt.button_event = judge_press(item.now_ms, item.button_level);
        elapsed   = item.now_ms - pair_start;
        since_ann = item.now_ms - last_announce;
        if (pair_open) begin
          if (elapsed > 32'(cfg_now.window_ms)) begin
            pair_open          = 1'b0;
            rpt.window_timeout = 1'b1;
          end else if (since_ann > 32'(cfg_now.retry_ms)) begin
            last_announce        = item.now_ms;
            rpt.announce_request = 1'b1;
            secs = (32'(cfg_now.window_ms) - elapsed) / MS_PER_S;
            rpt.seconds_left = (secs > 32'(bpw_pkg::SECONDS_MAX))
                               ? bpw_pkg::SECONDS_MAX : secs[bpw_pkg::SEC_W-1:0];
          end
        end
      end
      bpw_pkg::MODE_DELIVERED, bpw_pkg::MODE_SYNC: pair_open = 1'b0;
      bpw_pkg::MODE_UNPAIR: begin
        pair_open  = 1'b1;
        pair_start = item.now_ms;
      end
    endcase
    rpt.pairing_active = pair_open;
    return rpt;
  endfunction

  // ---------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------

  // send one input transaction, then hold off for a random gap
  task automatic send_item(input bpw_pkg::mode_t mode,
                           input logic [bpw_pkg::TIME_W-1:0] t,
                           input logic level);
    bpw_pkg::in_t item;
    int           gap;
    item     = bpw_pkg::in_t'{mode, t, level};
    clock_ms = t;
    in_if.valid <= 1'b1;
    in_if.data  <= item;
    do @(posedge clk); while (!in_if.ready);
    reports_due.push_back(next_report(item));
    items_sent++;
    if ($urandom_range(0, 49) == 0) src_steady = !src_steady;
    gap = src_steady ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_held = (gap == 0);
  endtask

  // drop valid and wait until every report has come back
  task automatic settle_block();
    if (in_held) begin
      in_if.valid <= 1'b0;
      in_held = 1'b0;
    end
    while (reports_due.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  // write one register and update the shadow copy
  task automatic write_reg(input logic [bpw_pkg::IDX_W-1:0] idx,
                           input logic [bpw_pkg::WIN_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= bpw_pkg::cfg_wr_t'{idx, value};
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      bpw_pkg::REG_BUTTON_ENABLED:  cfg_now.button_enabled  = value[0];
      bpw_pkg::REG_ACTIVE_LOW:      cfg_now.active_low      = value[0];
      bpw_pkg::REG_DEBOUNCE_MS:     cfg_now.debounce_ms     = value[bpw_pkg::MS_W-1:0];
      bpw_pkg::REG_LONG_PRESS_MS:   cfg_now.long_press_ms   = value[bpw_pkg::MS_W-1:0];
      bpw_pkg::REG_LONG_HOLDOFF_MS: cfg_now.long_holdoff_ms = value[bpw_pkg::MS_W-1:0];
      bpw_pkg::REG_WINDOW_MS:       cfg_now.window_ms       = value;
      bpw_pkg::REG_RETRY_MS:        cfg_now.retry_ms        = value[bpw_pkg::MS_W-1:0];
      default: ;
    endcase
  endtask

  // load a full setting; junk in the unused upper bits and one stray index
  task automatic apply_settings(input bpw_pkg::cfg_t c);
    logic [31:0] junk;
    junk = $urandom();
    write_reg(bpw_pkg::REG_BUTTON_ENABLED,  {junk[19:1], c.button_enabled});
    write_reg(bpw_pkg::REG_ACTIVE_LOW,      {junk[18:0], c.active_low});
    write_reg(bpw_pkg::REG_DEBOUNCE_MS,     {junk[3:0], c.debounce_ms});
    write_reg(bpw_pkg::REG_LONG_PRESS_MS,   {junk[7:4], c.long_press_ms});
    write_reg(bpw_pkg::REG_LONG_HOLDOFF_MS, {junk[11:8], c.long_holdoff_ms});
    write_reg(bpw_pkg::REG_WINDOW_MS,       c.window_ms);
    write_reg(bpw_pkg::REG_RETRY_MS,        {junk[15:12], c.retry_ms});
    write_reg(REG_UNUSED,                   junk[31:12]);
    cfg_if.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // time step between polls, aimed at the retry and window limits
  function automatic logic [bpw_pkg::TIME_W-1:0] pick_step();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 32'd1;
      2: return $urandom_range(0, 100);
      3: return 32'(cfg_now.retry_ms);
      4: return 32'(cfg_now.retry_ms) + 1;
      5: return $urandom_range(0, 2 * 32'(cfg_now.retry_ms) + 2);
      6: return $urandom_range(0, 32'(cfg_now.window_ms) / 3);
      7: return pair_open
                ? pair_start + 32'(cfg_now.window_ms) + $urandom_range(0, 1) - clock_ms
                : $urandom_range(0, 500);
      8: return $urandom_range(0, 3 * 32'(cfg_now.long_press_ms));
      default: return $urandom_range(0, 5000);
    endcase
  endfunction

  // hold length, mostly on either side of the debounce and long limits
  function automatic logic [bpw_pkg::TIME_W-1:0] pick_hold();
    logic [bpw_pkg::TIME_W-1:0] db;
    logic [bpw_pkg::TIME_W-1:0] lp;
    db = 32'(cfg_now.debounce_ms);
    lp = 32'(cfg_now.long_press_ms);
    case ($urandom_range(0, 7))
      0: return (db == 0) ? db : db - 1;
      1: return db;
      2: return db + $urandom_range(0, 2000);
      3: return lp - 1;
      4: return lp;
      5: return lp + $urandom_range(0, 3000);
      6: return $urandom_range(0, 100);
      default: return $urandom_range(0, 2 * lp);
    endcase
  endfunction

  // press, poll a few times while held, then release
  task automatic press_sequence();
    logic [bpw_pkg::TIME_W-1:0] hold;
    logic [bpw_pkg::TIME_W-1:0] t0;
    logic                       down;
    int                         taps;
    int                         i;
    down = !cfg_now.active_low;
    hold = pick_hold();
    taps = $urandom_range(0, 3);
    t0   = clock_ms + $urandom_range(1, 500);
    send_item(bpw_pkg::MODE_POLL, t0, down);
    for (i = 1; i <= taps; i++)
      send_item(bpw_pkg::MODE_POLL, t0 + (hold / 32'(taps + 1)) * 32'(i), down);
    if ($urandom_range(0, 1) == 1) send_item(bpw_pkg::MODE_POLL, t0 + hold, down);
    send_item(bpw_pkg::MODE_POLL, t0 + hold + $urandom_range(0, 2), !down);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // reset settings: no button; window driven by radio events only
  task automatic test_reset_settings();
    send_item(bpw_pkg::MODE_POLL, 32'd100, 1'b0);
    send_item(bpw_pkg::MODE_POLL, 32'd200, 1'b1);
    send_item(bpw_pkg::MODE_UNPAIR, 32'd1000, 1'b1);
    send_item(bpw_pkg::MODE_POLL, 32'd1000, 1'b0);
    send_item(bpw_pkg::MODE_POLL, 32'd3501, 1'b1);
    send_item(bpw_pkg::MODE_POLL, 32'd6001, 1'b1);
    send_item(bpw_pkg::MODE_POLL, 32'd6002, 1'b1);
    send_item(bpw_pkg::MODE_DELIVERED, 32'd6003, 1'b0);
    send_item(bpw_pkg::MODE_SYNC, 32'd6004, 1'b1);
    send_item(bpw_pkg::MODE_UNPAIR, 32'd6005, 1'b0);
    send_item(bpw_pkg::MODE_POLL, 32'd56006, 1'b1);
  endtask

  // short and long limits, holdoff, polarity and seconds saturation
  task automatic test_press_limits();
    logic [bpw_pkg::TIME_W-1:0] t;
    settle_block();
    apply_settings(bpw_pkg::cfg_t'{1'b1, 1'b1, bpw_pkg::RST_DEBOUNCE_MS,
                                   bpw_pkg::RST_LONG_PRESS_MS,
                                   bpw_pkg::RST_LONG_HOLDOFF_MS,
                                   bpw_pkg::RST_WINDOW_MS, bpw_pkg::RST_RETRY_MS});
    t = 32'd100000;
    // release right at the debounce limit gives a short press
    send_item(bpw_pkg::MODE_POLL, t, 1'b0);
    send_item(bpw_pkg::MODE_POLL, t + 50, 1'b1);
    // one below debounce gives nothing
    t += 1000;
    send_item(bpw_pkg::MODE_POLL, t, 1'b0);
    send_item(bpw_pkg::MODE_POLL, t + 49, 1'b1);
    // just under the long limit is still short
    t += 1000;
    send_item(bpw_pkg::MODE_POLL, t, 1'b0);
    send_item(bpw_pkg::MODE_POLL, t + 6999, 1'b1);
    // long press opens the window and announces at once; release is silent
    t += 10000;
    send_item(bpw_pkg::MODE_POLL, t, 1'b0);
    send_item(bpw_pkg::MODE_POLL, t + 7000, 1'b0);
    send_item(bpw_pkg::MODE_POLL, t + 7001, 1'b1);

    settle_block();
    apply_settings(bpw_pkg::cfg_t'{1'b1, 1'b0, 16'd0, 16'd1, 16'hFFFF, 20'hFFFFF, 16'd0});
    // active high; second long press inside the holdoff is blocked
    t += 20000;
    send_item(bpw_pkg::MODE_POLL, t, 1'b1);
    send_item(bpw_pkg::MODE_POLL, t + 1, 1'b1);
    send_item(bpw_pkg::MODE_POLL, t + 2, 1'b0);
    // zero-length press with zero debounce is short
    t += 100;
    send_item(bpw_pkg::MODE_POLL, t, 1'b1);
    send_item(bpw_pkg::MODE_POLL, t, 1'b0);
    // long press past the holdoff; huge window saturates the seconds
    t += 70000;
    send_item(bpw_pkg::MODE_POLL, t, 1'b1);
    send_item(bpw_pkg::MODE_POLL, t + 1, 1'b1);
    send_item(bpw_pkg::MODE_POLL, t + 1, 1'b0);
  endtask

  // random traffic over several settings, extremes first
  task automatic test_random_phases();
    bpw_pkg::cfg_t c;
    logic          al;
    int            phase;
    int            goal;
    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      settle_block();
      al = 1'($urandom_range(0, 1));
      case (phase)
        0: c = bpw_pkg::cfg_t'{1'b1, al, 16'd0, 16'd1, 16'd0, 20'd1000, 16'd0};
        1: c = bpw_pkg::cfg_t'{1'b1, al, 16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF,
                               16'hFFFF};
        default: begin
          c.button_enabled  = (phase != 2);
          c.active_low      = al;
          c.debounce_ms     = 16'($urandom_range(0, 300));
          c.long_press_ms   = 16'($urandom_range(1, 12000));
          c.long_holdoff_ms = 16'($urandom_range(0, 15000));
          c.window_ms       = (phase == 5) ? 20'($urandom_range(900000, 1000000))
                                           : 20'($urandom_range(1000, 120000));
          c.retry_ms        = 16'($urandom_range(0, 5000));
        end
      endcase
      apply_settings(c);
      // one phase runs across the 32-bit wrap of the millisecond clock
      clock_ms = (phase == 3) ? 32'hFFFF_FFFF - $urandom_range(0, 200000) : $urandom();
      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: press_sequence();
          4, 5, 6:
            repeat ($urandom_range(1, 6))
              send_item(bpw_pkg::MODE_POLL, clock_ms + pick_step(),
                        ($urandom_range(0, 9) == 0) ? !cfg_now.active_low
                                                    : cfg_now.active_low);
          7: send_item(bpw_pkg::mode_t'($urandom_range(1, 3)),
                       clock_ms + $urandom_range(0, 50), 1'($urandom_range(0, 1)));
          8: send_item(bpw_pkg::mode_t'($urandom_range(0, 3)), $urandom(),
                       1'($urandom_range(0, 1)));
          default: begin
            send_item(bpw_pkg::MODE_UNPAIR, clock_ms + $urandom_range(0, 100),
                      1'($urandom_range(0, 1)));
            repeat ($urandom_range(2, 8))
              send_item(bpw_pkg::MODE_POLL, clock_ms + pick_step(), cfg_now.active_low);
          end
        endcase
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------

  // accept results with random stalls and stretches without them
  initial begin : result_drain
    int stall;
    forever begin
      if ($urandom_range(0, 49) == 0) sink_steady = !sink_steady;
      stall = sink_steady ? 0 : $urandom_range(0, 12);
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  // compare each result transaction with the oldest expected report
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (reports_due.size() == 0) begin
        $error("result transaction with no report expected");
        mismatches++;
      end else begin
        want_rpt = reports_due.pop_front();
        got_rpt  = out_if.data;
        check_field("button_event", 32'(want_rpt.button_event),
                    32'(got_rpt.button_event));
        check_field("announce_request", 32'(want_rpt.announce_request),
                    32'(got_rpt.announce_request));
        check_field("seconds_left", 32'(want_rpt.seconds_left),
                    32'(got_rpt.seconds_left));
        check_field("window_timeout", 32'(want_rpt.window_timeout),
                    32'(got_rpt.window_timeout));
        check_field("pairing_active", 32'(want_rpt.pairing_active),
                    32'(got_rpt.pairing_active));
      end
    end
  end

  // end the run if it hangs
  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    rst_n        <= 1'b0;

    // reset shadow registers and predicted state
    cfg_now       = bpw_pkg::cfg_t'{bpw_pkg::RST_BUTTON_ENABLED, bpw_pkg::RST_ACTIVE_LOW,
                                    bpw_pkg::RST_DEBOUNCE_MS, bpw_pkg::RST_LONG_PRESS_MS,
                                    bpw_pkg::RST_LONG_HOLDOFF_MS, bpw_pkg::RST_WINDOW_MS,
                                    bpw_pkg::RST_RETRY_MS};
    pair_open     = 1'b0;
    pair_start    = '0;
    last_announce = '0;
    btn_down      = 1'b0;
    down_since    = '0;
    long_done     = 1'b0;
    last_long_at  = '0;
    clock_ms      = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_settings();
    test_press_limits();
    test_random_phases();

    settle_block();
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
